### design/ucv_pkg.sv
// Package for the UTF-16 to UTF-8 converter.
// Holds the transaction structs, the job record passed from front to back,
// and the sizing constants. No dependencies.
package ucv_pkg;

    localparam int LENGTH_BITS = 18;
    localparam int Q_DEPTH     = 2;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    localparam logic [15:0] SURR_LO   = 16'hD800;
    localparam logic [15:0] SURR_HI   = 16'hDFFF;
    localparam logic [15:0] ONE_LIMIT = 16'h0080;
    localparam logic [15:0] TWO_LIMIT = 16'h0800;
    localparam logic [20:0] PLANE_OFS = 21'h10000;
    localparam logic [7:0]  LEAD2     = 8'hC0;
    localparam logic [7:0]  LEAD3     = 8'hE0;
    localparam logic [7:0]  LEAD4     = 8'hF0;
    localparam logic [7:0]  CONT      = 8'h80;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        string_end;
    } t_in;

    typedef struct packed {
        logic [7:0]             out_byte;
        logic                   run_last;
        logic                   is_terminator;
        logic [LENGTH_BITS-1:0] utf8_length;
        logic                   dangling_half;
    } t_out;

    typedef struct packed {
        logic [3:0][7:0]        bytes;
        logic [2:0]             nbytes;
        logic                   term;
        logic [LENGTH_BITS-1:0] len;
        logic                   dang;
    } t_job;

endpackage

### design/ucv_front.sv
// Front end of the UTF-16 to UTF-8 converter: accepts code units, tracks
// surrogate pairs and the string byte count, and builds a job per unit that yields bytes or ends a string.
// Depends on ucv_pkg.
module ucv_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  ucv_pkg::t_in   i_in_data,
    input  logic           i_q_full,
    output logic           o_push,
    output ucv_pkg::t_job  o_job
);
    import ucv_pkg::*;

    logic [9:0]             r_held, n_held;
    logic                   r_pend, n_pend;
    logic [LENGTH_BITS-1:0] r_total, n_total;
    logic                   accept;
    logic [15:0]            c;
    logic [20:0]            cp;
    logic [2:0]             nb;
    logic [3:0][7:0]        bytes;
    logic [LENGTH_BITS:0]   sum;
    logic [LENGTH_BITS-1:0] sat;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign c          = i_in_data.code_unit;
    assign cp         = PLANE_OFS + {1'b0, r_held, c[9:0]};

    always_comb begin
        bytes  = '0;
        nb     = 3'd0;
        n_held = r_held;
        n_pend = r_pend;
        if (r_pend) begin
            bytes[0] = LEAD4 | {5'd0, cp[20:18]};
            bytes[1] = CONT | {2'd0, cp[17:12]};
            bytes[2] = CONT | {2'd0, cp[11:6]};
            bytes[3] = CONT | {2'd0, cp[5:0]};
            nb       = 3'd4;
            n_pend   = 1'b0;
            n_held   = '0;
        end else if (c < ONE_LIMIT) begin
            bytes[0] = c[7:0];
            nb       = 3'd1;
        end else if (c < TWO_LIMIT) begin
            bytes[0] = LEAD2 | {3'd0, c[10:6]};
            bytes[1] = CONT | {2'd0, c[5:0]};
            nb       = 3'd2;
        end else if (c inside {[SURR_LO:SURR_HI]}) begin
            n_held = c[9:0];
            n_pend = 1'b1;
        end else begin
            bytes[0] = LEAD3 | {4'd0, c[15:12]};
            bytes[1] = CONT | {2'd0, c[11:6]};
            bytes[2] = CONT | {2'd0, c[5:0]};
            nb       = 3'd3;
        end
        sum     = {1'b0, r_total} + {{(LENGTH_BITS-2){1'b0}}, nb};
        sat     = sum[LENGTH_BITS] ? '1 : sum[LENGTH_BITS-1:0];
        n_total = sat;
        if (i_in_data.string_end) begin
            n_total = '0;
            n_held  = '0;
        end
    end

    assign o_push       = accept && ((nb != 3'd0) || i_in_data.string_end);
    assign o_job.bytes  = bytes;
    assign o_job.nbytes = nb;
    assign o_job.term   = i_in_data.string_end;
    assign o_job.len    = sat;
    assign o_job.dang   = n_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= '0;
            r_pend  <= 1'b0;
            r_total <= '0;
        end else if (accept) begin
            r_held  <= n_held;
            r_pend  <= i_in_data.string_end ? 1'b0 : n_pend;
            r_total <= n_total;
        end
    end
endmodule

### design/ucv_queue.sv
// Short job queue between front and back of the converter.
// Register-based FIFO of Q_DEPTH jobs. Depends on ucv_pkg.
module ucv_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ucv_pkg::t_job  i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output ucv_pkg::t_job  o_job
);
    import ucv_pkg::*;

    t_job               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr, r_rd;
    logic [Q_CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

### design/ucv_back.sv
// Back end: pops jobs and sends their bytes, then any terminator, one per
// cycle unless stalled, via an output register. Depends on ucv_pkg.
module ucv_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  ucv_pkg::t_job  i_q_job,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output ucv_pkg::t_out  o_out_data
);
    import ucv_pkg::*;

    t_job       r_job;
    logic       r_busy;
    logic [2:0] r_idx;
    logic       r_out_valid;
    t_out       r_out, n_out;
    logic [2:0] total;
    logic       last;
    logic       can_load;
    logic       is_term;

    assign total    = r_job.nbytes + {2'd0, r_job.term};
    assign last     = (r_idx == total - 3'd1);
    assign can_load = !r_out_valid || !i_out_stall;
    assign o_pop    = i_q_valid && (!r_busy || (can_load && last));
    assign is_term  = (r_idx == r_job.nbytes);

    always_comb begin
        n_out.out_byte      = is_term ? 8'd0 : r_job.bytes[r_idx[1:0]];
        n_out.run_last      = last;
        n_out.is_terminator = is_term;
        n_out.utf8_length   = is_term ? r_job.len : '0;
        n_out.dangling_half = is_term && r_job.dang;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_q_job;
        end
        if (can_load) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (can_load) begin
                r_out_valid <= r_busy;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (can_load && r_busy) begin
                if (last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_idx <= r_idx + 3'd1;
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule

### design/utf16_to_utf8_converter.sv
// UTF-16 to UTF-8 converter top level: front end, job queue and back end.
// Depends on ucv_pkg, ucv_front, ucv_queue and ucv_back.
//
// Each accepted UTF-16 unit yields one to four UTF-8 bytes (none for the
// first half of a surrogate pair), plus a zero terminator carrying the
// saturating byte count on the unit marked string_end. Bytes leave one per
// cycle while the output is not stalled, through a registered output, so
// the byte port sets the rate: a pair yields four bytes, up to five
// transactions with the terminator. A two-entry job queue lets the front end
// take new units while the back end is still sending earlier bytes.
module utf16_to_utf8_converter (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  ucv_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output ucv_pkg::t_out  o_out_data
);
    import ucv_pkg::*;

    logic q_full, q_valid, push, pop;
    t_job push_job, pop_job;

    ucv_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_job      (push_job)
    );

    ucv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (pop_job)
    );

    ucv_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_job     (pop_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );
endmodule

### test/testbench.sv
`timescale 1ns / 100ps
// Testbench for utf16_to_utf8_converter: a directed table and random strings,
// checked against expected bytes in the table or an in-bench transcoder.
// Depends on ucv_pkg and the converter RTL.
module testbench;
    import ucv_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 8;
    localparam int RANDOM_UNITS = 135;
    localparam int LONG_HOLD    = 300;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS  = 10;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX  = '1;
    localparam logic [15:0]            LOW_HALF = 16'hDC00;

    typedef struct packed {
        logic [15:0]            unit;
        logic                   last;
        logic                   typed;
        logic [2:0]             nbytes;
        logic [31:0]            bytes;
        logic [LENGTH_BITS-1:0] len;
        logic                   dang;
    } t_row;

    localparam int NUM_ROWS = 21;
    localparam t_row DIRECTED [NUM_ROWS] = '{
        '{16'h0000, 1'b0, 1'b1, 3'd1, 32'h0000_0000, 18'd0, 1'b0},
        '{16'h007F, 1'b0, 1'b1, 3'd1, 32'h7F00_0000, 18'd0, 1'b0},
        '{16'h0080, 1'b0, 1'b1, 3'd2, 32'hC280_0000, 18'd0, 1'b0},
        '{16'h07FF, 1'b0, 1'b1, 3'd2, 32'hDFBF_0000, 18'd0, 1'b0},
        '{16'h0800, 1'b0, 1'b1, 3'd3, 32'hE0A0_8000, 18'd0, 1'b0},
        '{16'hFFFF, 1'b0, 1'b1, 3'd3, 32'hEFBF_BF00, 18'd0, 1'b0},
        '{16'hD7FF, 1'b0, 1'b1, 3'd3, 32'hED9F_BF00, 18'd0, 1'b0},
        '{16'hE000, 1'b0, 1'b1, 3'd3, 32'hEE80_8000, 18'd0, 1'b0},
        '{16'hD800, 1'b0, 1'b1, 3'd0, 32'h0000_0000, 18'd0, 1'b0},
        '{16'hDC00, 1'b0, 1'b1, 3'd4, 32'hF090_8080, 18'd0, 1'b0},
        '{16'hDBFF, 1'b0, 1'b1, 3'd0, 32'h0000_0000, 18'd0, 1'b0},
        '{16'hDFFF, 1'b0, 1'b1, 3'd4, 32'hF48F_BFBF, 18'd0, 1'b0},
        '{16'hDFFF, 1'b0, 1'b0, 3'd0, 32'h0000_0000, 18'd0, 1'b0},
        '{16'h0041, 1'b0, 1'b0, 3'd0, 32'h0000_0000, 18'd0, 1'b0},
        '{16'h1234, 1'b1, 1'b0, 3'd0, 32'h0000_0000, 18'd0, 1'b0},
        '{16'h0000, 1'b1, 1'b1, 3'd1, 32'h0000_0000, 18'd1, 1'b0},
        '{16'hD800, 1'b1, 1'b1, 3'd0, 32'h0000_0000, 18'd0, 1'b1},
        '{16'hDABC, 1'b0, 1'b0, 3'd0, 32'h0000_0000, 18'd0, 1'b0},
        '{16'hFFFF, 1'b1, 1'b0, 3'd0, 32'h0000_0000, 18'd0, 1'b0},
        '{16'h07FF, 1'b0, 1'b0, 3'd0, 32'h0000_0000, 18'd0, 1'b0},
        '{16'hDBFF, 1'b1, 1'b0, 3'd0, 32'h0000_0000, 18'd0, 1'b0}
    };

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    t_in  i_in_data   = '0;
    logic i_out_stall = 1'b0;
    logic o_in_stall;
    logic o_out_valid;
    t_out o_out_data;

    logic [9:0]             held_bits     = '0;
    logic                   half_held     = 1'b0;
    logic [LENGTH_BITS-1:0] string_bytes  = '0;
    t_out                   step_bytes [$];
    t_out                   pending_bytes [$];

    int   errors        = 0;
    int   idle_cycles   = 0;
    int   units_sent    = 0;
    logic tx_idling     = 1'b0;
    logic rx_idling     = 1'b0;
    logic long_hold_req = 1'b0;

    utf16_to_utf8_converter uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    function automatic t_out plain_byte(logic [7:0] b);
        t_out r;
        r = '0;
        r.out_byte = b;
        return r;
    endfunction

    function automatic t_out closing_byte(logic [LENGTH_BITS-1:0] len, logic dang);
        t_out r;
        r = '0;
        r.is_terminator = 1'b1;
        r.utf8_length   = len;
        r.dangling_half = dang;
        return r;
    endfunction

    function automatic string show(t_out r);
        return $sformatf("byte %02h last %0b term %0b len %0d dang %0b",
                         r.out_byte, r.run_last, r.is_terminator, r.utf8_length,
                         r.dangling_half);
    endfunction

    function automatic int idle_gap();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void transcode(t_in u);
        logic [20:0] cp;
        logic [15:0] c;
        int          n;
        c = u.code_unit;
        step_bytes.delete();
        if (half_held) begin
            cp = PLANE_OFS + {1'b0, held_bits, c[9:0]};
            step_bytes.push_back(plain_byte(LEAD4 | {5'b0, cp[20:18]}));
            step_bytes.push_back(plain_byte(CONT | {2'b0, cp[17:12]}));
            step_bytes.push_back(plain_byte(CONT | {2'b0, cp[11:6]}));
            step_bytes.push_back(plain_byte(CONT | {2'b0, cp[5:0]}));
            half_held = 1'b0;
            held_bits = '0;
        end else if (c < ONE_LIMIT) begin
            step_bytes.push_back(plain_byte(c[7:0]));
        end else if (c < TWO_LIMIT) begin
            step_bytes.push_back(plain_byte(LEAD2 | {3'b0, c[10:6]}));
            step_bytes.push_back(plain_byte(CONT | {2'b0, c[5:0]}));
        end else if (c >= SURR_LO && c <= SURR_HI) begin
            held_bits = c[9:0];
            half_held = 1'b1;
        end else begin
            step_bytes.push_back(plain_byte(LEAD3 | {4'b0, c[15:12]}));
            step_bytes.push_back(plain_byte(CONT | {2'b0, c[11:6]}));
            step_bytes.push_back(plain_byte(CONT | {2'b0, c[5:0]}));
        end
        n = step_bytes.size();
        if (string_bytes > LEN_MAX - n)
            string_bytes = LEN_MAX;
        else
            string_bytes = string_bytes + LENGTH_BITS'(n);
        if (u.string_end) begin
            step_bytes.push_back(closing_byte(string_bytes, half_held));
            half_held    = 1'b0;
            held_bits    = '0;
            string_bytes = '0;
        end
        if (step_bytes.size() > 0)
            step_bytes[step_bytes.size()-1].run_last = 1'b1;
    endfunction

    task automatic note_failure(string msg);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    task automatic send_unit(t_in u, logic typed, t_row row);
        int gap;
        int base;
        i_in_valid <= 1'b1;
        i_in_data  <= u;
        do @(posedge i_clk); while (o_in_stall);
        transcode(u);
        if (typed) begin
            base = pending_bytes.size();
            for (int k = 0; k < row.nbytes; k++)
                pending_bytes.push_back(plain_byte(row.bytes[31-8*k -: 8]));
            if (row.last)
                pending_bytes.push_back(closing_byte(row.len, row.dang));
            if (pending_bytes.size() > base)
                pending_bytes[pending_bytes.size()-1].run_last = 1'b1;
        end else begin
            foreach (step_bytes[i])
                pending_bytes.push_back(step_bytes[i]);
        end
        units_sent++;
        if (tx_idling && $urandom_range(0, 2) == 0) begin
            gap = idle_gap();
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic pause_until_drained();
        i_in_valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic send_random_string();
        logic [15:0] units [$];
        logic [15:0] v;
        int          count;
        t_in         u;
        count = $urandom_range(1, 8);
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 9))
                0, 1: units.push_back(16'($urandom_range(0, 'h7F)));
                2, 3: units.push_back(16'($urandom_range('h80, 'h7FF)));
                4, 5: begin
                    v = 16'($urandom_range('h800, 'hF7FF));
                    if (v >= SURR_LO)
                        v = v + 16'h0800;
                    units.push_back(v);
                end
                6, 7: begin
                    units.push_back(SURR_LO | 16'($urandom_range(0, 'h3FF)));
                    units.push_back(LOW_HALF | 16'($urandom_range(0, 'h3FF)));
                end
                8: units.push_back(16'($urandom));
                default: begin
                    units.push_back(SURR_LO + 16'($urandom_range(0, 'h7FF)));
                    units.push_back(16'($urandom));
                end
            endcase
        end
        if ($urandom_range(0, 7) == 0)
            units.push_back(SURR_LO + 16'($urandom_range(0, 'h7FF)));
        foreach (units[i]) begin
            u.code_unit  = units[i];
            u.string_end = (i == units.size() - 1);
            send_unit(u, 1'b0, '0);
        end
    endtask

    // receiver side: random stall gaps, plus one long hold on request
    initial begin : out_side
        int stall_len;
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_len     = LONG_HOLD;
            end else if (rx_idling && $urandom_range(0, 3) == 0) begin
                stall_len = idle_gap();
            end else begin
                stall_len = 0;
            end
            if (stall_len > 0) begin
                i_out_stall <= 1'b1;
                repeat (stall_len) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_bytes.size() == 0) begin
                note_failure($sformatf("unexpected output: %s", show(o_out_data)));
            end else begin
                want = pending_bytes.pop_front();
                if (o_out_data.out_byte      !== want.out_byte      ||
                    o_out_data.run_last      !== want.run_last      ||
                    o_out_data.is_terminator !== want.is_terminator ||
                    o_out_data.utf8_length   !== want.utf8_length   ||
                    o_out_data.dangling_half !== want.dangling_half)
                    note_failure($sformatf("mismatch: expected %s, got %s",
                                           show(want), show(o_out_data)));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        t_in         u;
        t_row        row;
        int          rand_start;
        logic        hold_done;
        logic        pause_done;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idling = 1'b1;
        rx_idling = 1'b1;
        for (int r = 0; r < NUM_ROWS; r++) begin
            row          = DIRECTED[r];
            u.code_unit  = row.unit;
            u.string_end = row.last;
            send_unit(u, row.typed, row);
        end
        pause_until_drained();

        rand_start = units_sent;
        while (units_sent - rand_start < RANDOM_UNITS) begin
            case ($urandom_range(0, 3))
                0: begin tx_idling = 1'b1; rx_idling = 1'b1; end
                1: begin tx_idling = 1'b0; rx_idling = 1'b0; end
                2: begin tx_idling = 1'b1; rx_idling = 1'b0; end
                default: begin tx_idling = 1'b0; rx_idling = 1'b1; end
            endcase
            if (!hold_done && units_sent - rand_start >= 40) begin
                hold_done     = 1'b1;
                tx_idling     = 1'b0;
                long_hold_req = 1'b1;
            end
            send_random_string();
            if (!pause_done && units_sent - rand_start >= 100) begin
                pause_done = 1'b1;
                pause_until_drained();
            end
        end
        i_in_valid <= 1'b0;

        while (pending_bytes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending_bytes.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### utf16_to_utf8_converter.f
design/ucv_pkg.sv
design/ucv_front.sv
design/ucv_queue.sv
design/ucv_back.sv
design/utf16_to_utf8_converter.sv
test/testbench.sv
